// ===== rtl/wbp_pkg.sv =====
// Shared constants and types of the wavelet band power block.
package wbp_pkg;

	localparam int COEF_W  = 16;  // signed Q1.15 coefficient
	localparam int NORM_W  = 31;  // square of one coefficient, unsigned Q1.30
	localparam int BAND_W  = 4;   // band index
	localparam int BANDS_W = 5;   // band count, 1..MAX_LOG2_LENGTH after clamping
	localparam int POWER_W = 32;  // unsigned Q16.16 result
	localparam int FRAC_W  = 16;  // fraction bits of the result
	localparam int CFG_W   = 4;   // width of the length register

	localparam logic [CFG_W-1:0] LOG2_LENGTH_RESET = 4'd10;

	// Register index of log2_length on the configuration port
	localparam logic REG_LOG2_LENGTH = 1'b0;

	// Pending band results between the front and the divider
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	typedef struct packed {
		logic [BAND_W-1:0] band;
		logic              last;
	} band_ctl_t;

endpackage

// ===== rtl/wavelet_band_power_top.sv =====
// Top level of the wavelet band power block: ports, register and wiring.
//
// Input stream (s_*): one signed Q1.15 wavelet coefficient per item, in
// vector order. A vector holds 2^log2_length coefficients; the first is the
// normalizer, the rest form dyadic bands of 1, 2, 4, ... coefficients.
// Output stream (m_*): one item per completed band carrying the band index,
// the band energy over the normalizer as unsigned Q16.16 (saturated) and
// tlast on the final band of a vector. A zero normalizer gives zero power.
// Configuration: APB register 0 (log2_length, reset 10), for the user to write
// only while idle; the block itself does not enforce this. Coefficients are
// taken at one per cycle while s_tready is high. A band result holds the
// divider for load, 32 quotient bits and hand-off, or for load and hand-off
// alone with a zero normalizer or a saturated ratio; a four-entry queue buffers
// pending band sums, and the input stalls only while that queue could overflow.
// A band's result passes the square register, the queue and the divider in turn.
// Reset clears positions, sums, queue and output valid; log2_length
// returns to 10. A stalled receiver holds the output item, then the
// divider, then the queue, and finally the input.
module wavelet_band_power_top import wbp_pkg::*; #(
	parameter int MAX_LOG2_LENGTH = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Coefficient stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] coef
	// Band result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [3:0] band, [35:4] band_power, [39:36] zero
	output logic        m_tlast    // last_band
);

	localparam int ACC_W = MAX_LOG2_LENGTH + 30;
	localparam int QW    = BAND_W + 1 + ACC_W + NORM_W;

	logic [CFG_W-1:0]   log2_length_q;
	logic [QCNT_W-1:0]  q_count;
	logic               push;
	band_ctl_t          push_ctl;
	logic [ACC_W-1:0]   push_sum;
	logic [NORM_W-1:0]  push_norm;
	logic [QW-1:0]      head;
	logic               q_valid;
	logic               pop;
	band_ctl_t          out_ctl;
	logic [POWER_W-1:0] out_power;

	// Length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log2_length_q <= LOG2_LENGTH_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_LOG2_LENGTH)) begin
			log2_length_q <= pwdata[CFG_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_LOG2_LENGTH) ? {{(32-CFG_W){1'b0}}, log2_length_q} : '0;

	wbp_front #(
		.MAX_LOG2_LENGTH(MAX_LOG2_LENGTH),
		.ACC_W(ACC_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.log2_length(log2_length_q),
		.coef_valid (s_tvalid),
		.coef_ready (s_tready),
		.coef       (s_tdata),
		.q_count    (q_count),
		.push       (push),
		.push_ctl   (push_ctl),
		.push_sum   (push_sum),
		.push_norm  (push_norm)
	);

	wbp_queue #(
		.WIDTH(QW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data({push_ctl, push_sum, push_norm}),
		.pop      (pop),
		.head     (head),
		.nonempty (q_valid),
		.count    (q_count)
	);

	wbp_back #(
		.ACC_W(ACC_W)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.pop      (pop),
		.q_ctl    (head[QW-1 -: BAND_W+1]),
		.q_sum    (head[NORM_W +: ACC_W]),
		.q_norm   (head[NORM_W-1:0]),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_ctl  (out_ctl),
		.out_power(out_power)
	);

	assign m_tdata = {4'b0000, out_power, out_ctl.band};
	assign m_tlast = out_ctl.last;

endmodule

// ===== rtl/wbp_front.sv =====
// Front part: squares coefficients, tracks bands and sums each band.
module wbp_front import wbp_pkg::*; #(
	parameter int MAX_LOG2_LENGTH = 10,
	parameter int ACC_W           = 40
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [CFG_W-1:0]         log2_length,
	input  logic                     coef_valid,
	output logic                     coef_ready,
	input  logic signed [COEF_W-1:0] coef,
	input  logic [QCNT_W-1:0]        q_count,
	output logic                     push,
	output band_ctl_t                push_ctl,
	output logic [ACC_W-1:0]         push_sum,
	output logic [NORM_W-1:0]        push_norm
);

	localparam int POS_W = MAX_LOG2_LENGTH;

	logic [POS_W-1:0]         pos_q;
	logic [BAND_W-1:0]        band_q;
	logic [BANDS_W-1:0]       bands;
	logic [POS_W:0]           band_end;
	logic                     first;
	logic                     is_end;
	logic                     is_last;
	logic                     accept;
	logic signed [2*COEF_W-1:0] prod;

	logic                     valid_s1;
	logic                     first_s1;
	logic                     end_s1;
	band_ctl_t                ctl_s1;
	logic [NORM_W-1:0]        sq_s1;

	logic [NORM_W-1:0]        norm_q;
	logic [ACC_W-1:0]         acc_q;
	logic [ACC_W-1:0]         acc_sum;

	// Clamp the length register into the supported band count
	always_comb begin
		bands = BANDS_W'(log2_length);
		if (bands == '0) begin
			bands = BANDS_W'(1);
		end
		if (bands > BANDS_W'(MAX_LOG2_LENGTH)) begin
			bands = BANDS_W'(MAX_LOG2_LENGTH);
		end
	end

	// Classify the incoming coefficient
	assign first    = (pos_q == '0);
	assign band_end = ({{POS_W{1'b0}}, 1'b1} << ({1'b0, band_q} + BANDS_W'(1)))
		- {{POS_W{1'b0}}, 1'b1};
	assign is_end   = !first && ({1'b0, pos_q} == band_end);
	assign is_last  = ({1'b0, band_q} + BANDS_W'(1)) >= bands;
	assign prod     = coef * coef;

	// Hold off while the queue could not take the pending result
	assign coef_ready = (q_count + QCNT_W'(valid_s1 && end_s1)) < QCNT_W'(QUEUE_DEPTH);
	assign accept     = coef_valid && coef_ready;

	// Advance position and band on every accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			band_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				if (first) begin
					pos_q  <= POS_W'(1);
					band_q <= '0;
				end else if (is_end && is_last) begin
					pos_q  <= '0;
					band_q <= '0;
				end else if (is_end) begin
					pos_q  <= pos_q + POS_W'(1);
					band_q <= band_q + BAND_W'(1);
				end else begin
					pos_q  <= pos_q + POS_W'(1);
				end
			end
		end
	end

	// Register the square and the item's class
	always_ff @(posedge clk) begin
		if (accept) begin
			sq_s1         <= prod[NORM_W-1:0];
			first_s1      <= first;
			end_s1        <= is_end;
			ctl_s1.band   <= band_q;
			ctl_s1.last   <= is_last;
		end
	end

	assign acc_sum = acc_q + ACC_W'(sq_s1);

	// Keep the normalizer and the running band sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			norm_q <= '0;
			acc_q  <= '0;
		end else if (valid_s1) begin
			if (first_s1) begin
				norm_q <= sq_s1;
				acc_q  <= '0;
			end else if (end_s1) begin
				acc_q  <= '0;
			end else begin
				acc_q  <= acc_sum;
			end
		end
	end

	assign push      = valid_s1 && !first_s1 && end_s1;
	assign push_ctl  = ctl_s1;
	assign push_sum  = acc_sum;
	assign push_norm = norm_q;

endmodule

// ===== rtl/wbp_queue.sv =====
// Small queue of completed band sums waiting for the divider.
module wbp_queue import wbp_pkg::*; #(
	parameter int WIDTH = 76
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [WIDTH-1:0]  push_data,
	input  logic              pop,
	output logic [WIDTH-1:0]  head,
	output logic              nonempty,
	output logic [QCNT_W-1:0] count
);

	logic [WIDTH-1:0]  mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	assign head     = mem[rd_ptr_q];
	assign nonempty = (count_q != '0);
	assign count    = count_q;

endmodule

// ===== rtl/wbp_back.sv =====
// Back part: divides each band sum by the normalizer, one quotient bit a cycle.
module wbp_back import wbp_pkg::*; #(
	parameter int ACC_W = 40
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	output logic               pop,
	input  band_ctl_t          q_ctl,
	input  logic [ACC_W-1:0]   q_sum,
	input  logic [NORM_W-1:0]  q_norm,
	output logic               out_valid,
	input  logic               out_ready,
	output band_ctl_t          out_ctl,
	output logic [POWER_W-1:0] out_power
);

	localparam int CMP_W = (ACC_W > NORM_W + FRAC_W) ? ACC_W : NORM_W + FRAC_W;
	localparam int CNT_W = $clog2(POWER_W);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_HOLD
	} state_t;

	state_t             state_q;
	band_ctl_t          ctl_q;
	logic [NORM_W-1:0]  norm_q;
	logic [NORM_W-1:0]  rem_q;
	logic [POWER_W-1:0] dq_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               out_valid_q;
	band_ctl_t          out_ctl_q;
	logic [POWER_W-1:0] out_power_q;

	logic               saturate;
	logic [NORM_W:0]    rem_sh;
	logic [NORM_W:0]    rem_sub;
	logic               ge;

	// Quotient reaches 2^32 exactly when the sum reaches norm * 2^16
	assign saturate = CMP_W'(q_sum) >= (CMP_W'(q_norm) << FRAC_W);

	// One restoring step
	assign rem_sh  = {rem_q, dq_q[POWER_W-1]};
	assign rem_sub = rem_sh - {1'b0, norm_q};
	assign ge      = rem_sh >= {1'b0, norm_q};

	assign pop = (state_q == ST_IDLE) && q_valid;

	// Sequence divisions and hold the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
			ctl_q       <= '0;
			norm_q      <= '0;
			rem_q       <= '0;
			dq_q        <= '0;
			out_ctl_q   <= '0;
			out_power_q <= '0;
		end else begin
			// Drop the output item once taken, unless a new one replaces it
			if (out_valid_q && out_ready && (state_q != ST_HOLD)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						ctl_q  <= q_ctl;
						norm_q <= q_norm;
						if (q_norm == '0) begin
							dq_q    <= '0;
							state_q <= ST_HOLD;
						end else if (saturate) begin
							dq_q    <= '1;
							state_q <= ST_HOLD;
						end else begin
							rem_q   <= NORM_W'(q_sum >> FRAC_W);
							dq_q    <= {q_sum[FRAC_W-1:0], {(POWER_W-FRAC_W){1'b0}}};
							cnt_q   <= CNT_W'(POWER_W - 1);
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					rem_q <= ge ? rem_sub[NORM_W-1:0] : rem_sh[NORM_W-1:0];
					dq_q  <= {dq_q[POWER_W-2:0], ge};
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == '0) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_ctl_q   <= ctl_q;
						out_power_q <= dq_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_ctl   = out_ctl_q;
	assign out_power = out_power_q;

endmodule
